// File: design/s8d_pkg.sv
// Shared types, constants and decode functions for the strict UTF-8 stream decoder.
// No dependencies; used by every module of the block.
package s8d_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // Byte boundaries of the strict UTF-8 rules
    localparam logic [7:0] BYTE_ASCII_END = 8'h80;
    localparam logic [7:0] LEAD2_MIN      = 8'hC2;
    localparam logic [7:0] LEAD3_MIN      = 8'hE0;
    localparam logic [7:0] LEAD3_SURR     = 8'hED;
    localparam logic [7:0] LEAD4_MIN      = 8'hF0;
    localparam logic [7:0] LEAD4_TOP      = 8'hF4;
    localparam logic [7:0] LEAD_LIMIT     = 8'hF5;
    localparam logic [7:0] CONT_LO        = 8'h80;
    localparam logic [7:0] CONT_HI        = 8'hBF;
    localparam logic [7:0] E0_LO          = 8'hA0;
    localparam logic [7:0] ED_HI          = 8'h9F;
    localparam logic [7:0] F0_LO          = 8'h90;
    localparam logic [7:0] F4_HI          = 8'h8F;
    localparam logic [7:0] CONT_MASK      = 8'hC0;

    localparam logic [20:0] CP_REPL = 21'h00FFFD;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;
    localparam logic [1:0] ST_CLEAN_END  = 2'd3;

    // decode outcomes
    localparam logic [1:0] DEC_OK   = 2'd0;
    localparam logic [1:0] DEC_BAD  = 2'd1;
    localparam logic [1:0] DEC_WAIT = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
    } in_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  status;
        logic [31:0] seq_offset;
        logic        last_result;
    } out_t;

    // byte plus its lead classification; need == 0 marks an illegal lead
    typedef struct packed {
        logic [7:0] b;
        logic [2:0] need;
        logic [7:0] lo;
        logic [7:0] hi;
    } hbyte_t;

    typedef hbyte_t [3:0] hbuf_t;

    typedef struct packed {
        hbyte_t hb;
        logic   is_end;
    } qitem_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  len;
        logic [20:0] cp;
    } dec_t;

    function automatic hbyte_t lead_class(input logic [7:0] b);
        hbyte_t h;
        h.b    = b;
        h.need = 3'd0;
        h.lo   = CONT_LO;
        h.hi   = CONT_HI;
        if (b < BYTE_ASCII_END) begin
            h.need = 3'd1;
        end else if (b < LEAD2_MIN || b >= LEAD_LIMIT) begin
            h.need = 3'd0;
        end else if (b < LEAD3_MIN) begin
            h.need = 3'd2;
        end else if (b < LEAD4_MIN) begin
            h.need = 3'd3;
            if (b == LEAD3_MIN) h.lo = E0_LO;
            else if (b == LEAD3_SURR) h.hi = ED_HI;
        end else begin
            h.need = 3'd4;
            if (b == LEAD4_MIN) h.lo = F0_LO;
            else if (b == LEAD4_TOP) h.hi = F4_HI;
        end
        return h;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_LO;
    endfunction

    // Judge the sequence at the front of w (n valid bytes, 0..4).
    function automatic dec_t decode(input hbuf_t w, input logic [2:0] n);
        dec_t d;
        d.kind = DEC_OK;
        d.len  = 3'd1;
        d.cp   = CP_REPL;
        if (n == 3'd0) begin
            d.kind = DEC_WAIT;
        end else if (w[0].need == 3'd1) begin
            d.cp = {13'd0, w[0].b};
        end else if (w[0].need == 3'd0) begin
            d.kind = DEC_BAD;
        end else if (n < w[0].need) begin
            d.kind = DEC_WAIT;
        end else if (w[1].b < w[0].lo || w[1].b > w[0].hi) begin
            d.kind = DEC_BAD;
        end else if (w[0].need >= 3'd3 && !is_cont(w[2].b)) begin
            d.kind = DEC_BAD;
        end else if (w[0].need == 3'd4 && !is_cont(w[3].b)) begin
            d.kind = DEC_BAD;
        end else begin
            d.len = w[0].need;
            if (w[0].need == 3'd2)
                d.cp = {10'd0, w[0].b[4:0], w[1].b[5:0]};
            else if (w[0].need == 3'd3)
                d.cp = {5'd0, w[0].b[3:0], w[1].b[5:0], w[2].b[5:0]};
            else
                d.cp = {w[0].b[2:0], w[1].b[5:0], w[2].b[5:0], w[3].b[5:0]};
        end
        return d;
    endfunction

endpackage

// File: design/strict_utf8_stream_decoder.sv
// Strict UTF-8 stream decoder, top level: front queue, decode engine, result queue.
// Depends on s8d_pkg, s8d_front, s8d_back and s8d_fifo.
// Each byte is registered in the front queue and its result in the result queue.
// Throughput: one item per cycle while each byte gives at most one result and the result queue
// has room; an item with more than one result holds the decode engine until all are emitted (one result per cycle).
// Reset (async, active low) empties both queues, clears held count and offsets, not bytes.
module strict_utf8_stream_decoder #(
    parameter int OFFSET_WIDTH = s8d_pkg::OFFSET_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = s8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    // byte stream in
    input  logic          push,
    output logic          full,
    input  s8d_pkg::in_t  item,
    // decoded results out
    input  logic          pop,
    output logic          empty,
    output s8d_pkg::out_t result
);

    // front-to-back queue
    logic            q_pop;
    logic            q_empty;
    s8d_pkg::qitem_t q_item;

    // back-to-output queue
    logic            res_push;
    logic            res_full;
    s8d_pkg::out_t   res;

    // Front: classifies each byte as ASCII, a 2/3/4-byte lead with its allowed
    // second-byte window, or an illegal lead, then queues it.
    s8d_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_item  (q_item)
    );

    // Back: appends the byte to up to three held bytes and emits one result per
    // cycle unless the result queue is full. A bad sequence drops only its lead and
    // the rest is re-judged; a one-step lookahead marks the final result of each item.
    s8d_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .out_full (res_full),
        .res_push (res_push),
        .res      (res)
    );

    // Result queue decouples the engine from a stalled consumer.
    s8d_fifo #(
        .T     (s8d_pkg::out_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// File: design/s8d_fifo.sv
// Small register queue with full/empty flags, generic over the entry type.
// Depends on s8d_pkg for the default depth.
module s8d_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = s8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    T                 mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: design/s8d_front.sv
// Front end: accepts stream items, classifies each byte as a lead, and queues it.
// Depends on s8d_pkg and s8d_fifo.
module s8d_front #(
    parameter int QUEUE_DEPTH = s8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  s8d_pkg::in_t    item,
    input  logic            q_pop,
    output logic            q_empty,
    output s8d_pkg::qitem_t q_item
);

    s8d_pkg::qitem_t cls;

    always_comb
    begin
        cls.hb     = s8d_pkg::lead_class(item.data_byte);
        cls.is_end = item.is_end;
    end

    s8d_fifo #(
        .T     (s8d_pkg::qitem_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_item),
        .empty   (q_empty)
    );

endmodule

// File: design/s8d_back.sv
// Back end: holds pending bytes, judges sequences and emits one result per cycle unless out_full stalls it.
// Depends on s8d_pkg.
module s8d_back #(
    parameter int OFFSET_WIDTH = s8d_pkg::OFFSET_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  s8d_pkg::qitem_t q_item,
    output logic            q_pop,
    input  logic            out_full,
    output logic            res_push,
    output s8d_pkg::out_t   res
);

    s8d_pkg::hbuf_t          buf_reg, buf_next;
    logic [1:0]              n_reg, n_next;
    logic                    scan_reg, scan_next;
    logic [OFFSET_WIDTH-1:0] byte_off_reg, byte_off_next;
    logic [OFFSET_WIDTH-1:0] head_off_reg, head_off_next;

    s8d_pkg::hbuf_t          wbuf, sbuf;
    logic [2:0]              wn, sn;
    s8d_pkg::dec_t           d0, d1;
    logic                    take, step, last;

    always_comb
    begin
        // working view: held bytes, plus the incoming byte when a new item is taken
        wbuf = buf_reg;
        wn   = {1'b0, n_reg};
        if (!scan_reg)
        begin
            wbuf[n_reg] = q_item.hb;
            wn          = {1'b0, n_reg} + 3'd1;
        end
        d0 = s8d_pkg::decode(wbuf, wn);

        // remainder after the judged sequence, shifted to the front
        sbuf = '0;
        unique case (d0.len)
            3'd1:    sbuf[2:0] = wbuf[3:1];
            3'd2:    sbuf[1:0] = wbuf[3:2];
            3'd3:    sbuf[0]   = wbuf[3];
            default: ;
        endcase
        sn = wn - d0.len;
        // lookahead: does the remainder yield another result this item?
        d1   = s8d_pkg::decode(sbuf, sn);
        last = (d1.kind == s8d_pkg::DEC_WAIT);

        take  = !scan_reg && !q_empty && !out_full;
        step  = scan_reg && !out_full;
        q_pop = take;

        buf_next      = buf_reg;
        n_next        = n_reg;
        scan_next     = scan_reg;
        byte_off_next = byte_off_reg;
        head_off_next = head_off_reg;
        res_push      = 1'b0;
        res.code_point  = d0.cp;
        res.status      = (d0.kind == s8d_pkg::DEC_OK) ? s8d_pkg::ST_OK : s8d_pkg::ST_INVALID;
        res.seq_offset  = 32'(head_off_reg);
        res.last_result = last;

        if (take && q_item.is_end)
        begin
            res_push        = 1'b1;
            res.last_result = 1'b1;
            if (n_reg != 2'd0)
            begin
                res.code_point = s8d_pkg::CP_REPL;
                res.status     = s8d_pkg::ST_INCOMPLETE;
            end
            else
            begin
                res.code_point = '0;
                res.status     = s8d_pkg::ST_CLEAN_END;
                res.seq_offset = 32'(byte_off_reg);
            end
            n_next        = 2'd0;
            byte_off_next = '0;
            head_off_next = '0;
        end
        else if (take || step)
        begin
            if (take)
                byte_off_next = byte_off_reg + OFFSET_WIDTH'(1);
            if (d0.kind == s8d_pkg::DEC_WAIT)
            begin
                buf_next  = wbuf;
                n_next    = wn[1:0];
                scan_next = 1'b0;
            end
            else
            begin
                res_push      = 1'b1;
                buf_next      = sbuf;
                n_next        = sn[1:0];
                head_off_next = head_off_reg + OFFSET_WIDTH'(d0.len);
                scan_next     = !last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg        <= 2'd0;
            scan_reg     <= 1'b0;
            byte_off_reg <= '0;
            head_off_reg <= '0;
        end
        else
        begin
            n_reg        <= n_next;
            scan_reg     <= scan_next;
            byte_off_reg <= byte_off_next;
            head_off_reg <= head_off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// File: bench/tb_strict_utf8_stream_decoder.sv
// Self-checking bench for strict_utf8_stream_decoder: a directed table, then random streams.
// Results are checked against a predictor of the decoder that lives in this file.
// Depends on s8d_pkg and the decoder RTL.
module tb_strict_utf8_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    logic          clk;
    logic          rst_n;
    logic          push;
    logic          full;
    s8d_pkg::in_t  item;
    logic          pop;
    logic          empty;
    s8d_pkg::out_t result;

    strict_utf8_stream_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    // Predictor state: bytes still waiting for the rest of their sequence,
    // and the stream offset of the next byte.
    logic [2:0][7:0] held_bytes;
    int              held_n;
    logic [31:0]     next_off;

    // Decoded results still owed by the block, oldest first.
    s8d_pkg::out_t predicted_cps [$];

    // Random stimulus waiting to be fed, one item per entry.
    s8d_pkg::in_t  byte_plan [$];

    int   mismatches;
    int   fed_items;
    int   gap_pct;      // chance in 100 that the sender idles on a cycle
    int   stall_pct;    // chance in 100 that the receiver holds off pop

    // One row of the directed table. Where typed is set, want is the single
    // result the item must produce; otherwise the predictor supplies it.
    typedef struct {
        s8d_pkg::in_t  stim;
        bit            typed;
        s8d_pkg::out_t want;
    } row_t;

    row_t rows [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (every item giving four
    // results, each held up by an 84% receiver stall).
    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Judge the sequence at the front of w, of which n bytes are present.
    // A bad lead or bad continuation gives the replacement char and
    // consumes the lead only.
    function automatic logic [1:0] judge_front(input logic [3:0][7:0] w, input int n,
                                               output logic [20:0] cp, output int len);
        logic [7:0] lo;
        logic [7:0] hi;
        int         need;
        cp  = s8d_pkg::CP_REPL;
        len = 1;
        lo  = s8d_pkg::CONT_LO;
        hi  = s8d_pkg::CONT_HI;
        if (w[0] < s8d_pkg::BYTE_ASCII_END)
        begin
            cp = {13'd0, w[0]};
            return s8d_pkg::DEC_OK;
        end
        if (w[0] < s8d_pkg::LEAD2_MIN || w[0] >= s8d_pkg::LEAD_LIMIT)
            return s8d_pkg::DEC_BAD;
        if (w[0] < s8d_pkg::LEAD3_MIN)
            need = 2;
        else if (w[0] < s8d_pkg::LEAD4_MIN)
        begin
            need = 3;
            // E0 would be overlong below A0; ED would reach the surrogates above 9F
            if (w[0] == s8d_pkg::LEAD3_MIN)
                lo = s8d_pkg::E0_LO;
            else if (w[0] == s8d_pkg::LEAD3_SURR)
                hi = s8d_pkg::ED_HI;
        end
        else
        begin
            need = 4;
            // F0 would be overlong below 90; F4 would pass U+10FFFF above 8F
            if (w[0] == s8d_pkg::LEAD4_MIN)
                lo = s8d_pkg::F0_LO;
            else if (w[0] == s8d_pkg::LEAD4_TOP)
                hi = s8d_pkg::F4_HI;
        end
        if (n < need)
            return s8d_pkg::DEC_WAIT;
        if (w[1] < lo || w[1] > hi)
            return s8d_pkg::DEC_BAD;
        if (need >= 3 && w[2][7:6] != 2'b10)
            return s8d_pkg::DEC_BAD;
        if (need == 4 && w[3][7:6] != 2'b10)
            return s8d_pkg::DEC_BAD;
        case (need)
            2: cp = {10'd0, w[0][4:0], w[1][5:0]};
            3: cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
            default: cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
        endcase
        len = need;
        return s8d_pkg::DEC_OK;
    endfunction

    // Advance the predictor by one accepted item and queue what it owes.
    task automatic predict_decode(input s8d_pkg::in_t x, input bit typed,
                                  input s8d_pkg::out_t want);
        logic [3:0][7:0] win;
        logic [20:0]     cp;
        logic [1:0]      verdict;
        logic [31:0]     start;
        int              n;
        int              pos;
        int              len;
        int              i;
        s8d_pkg::out_t   r;
        s8d_pkg::out_t   batch [$];
        n     = held_n;
        start = next_off - n;
        if (x.is_end)
        begin
            // flush: one result, then the stream starts over at offset 0
            r.code_point  = (n > 0) ? s8d_pkg::CP_REPL : 21'd0;
            r.status      = (n > 0) ? s8d_pkg::ST_INCOMPLETE : s8d_pkg::ST_CLEAN_END;
            r.seq_offset  = (n > 0) ? start : next_off;
            r.last_result = 1'b1;
            batch.push_back(r);
            held_n   = 0;
            next_off = '0;
        end
        else
        begin
            win = '0;
            for (i = 0; i < n; i++)
                win[i] = held_bytes[i];
            win[n] = x.data_byte;
            n++;
            next_off = next_off + 1;
            pos     = 0;
            verdict = s8d_pkg::DEC_OK;
            // a bad lead consumes one byte and the rest are looked at again
            while (pos < n && verdict != s8d_pkg::DEC_WAIT)
            begin
                verdict = judge_front(win >> (8 * pos), n - pos, cp, len);
                if (verdict != s8d_pkg::DEC_WAIT)
                begin
                    r.code_point  = cp;
                    r.status      = (verdict == s8d_pkg::DEC_OK) ? s8d_pkg::ST_OK
                                                                 : s8d_pkg::ST_INVALID;
                    r.seq_offset  = start + pos;
                    r.last_result = 1'b0;
                    batch.push_back(r);
                    pos += len;
                end
            end
            held_n = n - pos;
            for (i = 0; i < held_n; i++)
                held_bytes[i] = win[pos + i];
            if (batch.size() > 0)
                batch[batch.size() - 1].last_result = 1'b1;
        end
        if (typed)
            predicted_cps.push_back(want);
        else
            foreach (batch[k])
                predicted_cps.push_back(batch[k]);
    endtask

    // Offer one item, idling first at random, and account for it once it is
    // taken. Called right after a rising edge; returns at the accepting edge.
    task automatic feed(input s8d_pkg::in_t x, input bit typed, input s8d_pkg::out_t want);
        while ($urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= x;
        do
            @(posedge clk);
        while (full);
        predict_decode(x, typed, want);
        fed_items++;
    endtask

    task automatic add_row(input logic [7:0] b, input logic is_end, input bit typed,
                           input logic [20:0] cp, input logic [1:0] st,
                           input logic [31:0] off);
        row_t r;
        r.stim.data_byte     = b;
        r.stim.is_end        = is_end;
        r.typed              = typed;
        r.want.code_point    = cp;
        r.want.status        = st;
        r.want.seq_offset    = off;
        r.want.last_result   = 1'b1;
        rows.push_back(r);
    endtask

    // Build one random burst into byte_plan. Nearly half are well-formed sequences
    // with random scalars; the rest are damaged sequences, leads with tight
    // second-byte ranges, stray bytes and end-of-stream flushes.
    task automatic plan_burst();
        int           mix;
        int           len;
        int           at;
        logic [20:0]  cp;
        logic [7:0]   seq [$];
        s8d_pkg::in_t x;
        mix = $urandom_range(99);
        if (mix < 6)
        begin
            x.data_byte = 8'($urandom_range(255));
            x.is_end    = 1'b1;
            byte_plan.push_back(x);
            return;
        end
        if (mix < 22)
        begin
            len = $urandom_range(1, 3);
            repeat (len)
                seq.push_back(8'($urandom_range(255)));
        end
        else if (mix < 34)
        begin
            case ($urandom_range(3))
                0: seq.push_back(s8d_pkg::LEAD3_MIN);
                1: seq.push_back(s8d_pkg::LEAD3_SURR);
                2: seq.push_back(s8d_pkg::LEAD4_MIN);
                default: seq.push_back(s8d_pkg::LEAD4_TOP);
            endcase
            len = (seq[0] >= s8d_pkg::LEAD4_MIN) ? 3 : 2;
            repeat (len)
                seq.push_back(8'($urandom_range(s8d_pkg::CONT_LO, s8d_pkg::CONT_HI)));
        end
        else
        begin
            len = $urandom_range(1, 4);
            case (len)
                1:
                begin
                    cp = 21'($urandom_range(21'h7F));
                    seq.push_back(cp[7:0]);
                end
                2:
                begin
                    cp = 21'($urandom_range(21'h80, 21'h7FF));
                    seq.push_back({3'b110, cp[10:6]});
                    seq.push_back({2'b10, cp[5:0]});
                end
                3:
                begin
                    do
                        cp = 21'($urandom_range(21'h800, 21'hFFFF));
                    while (cp >= 21'hD800 && cp <= 21'hDFFF);
                    seq.push_back({4'b1110, cp[15:12]});
                    seq.push_back({2'b10, cp[11:6]});
                    seq.push_back({2'b10, cp[5:0]});
                end
                default:
                begin
                    cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                    seq.push_back({5'b11110, cp[20:18]});
                    seq.push_back({2'b10, cp[17:12]});
                    seq.push_back({2'b10, cp[11:6]});
                    seq.push_back({2'b10, cp[5:0]});
                end
            endcase
            // damage about one in four: swap a byte, or cut the tail off (a lone byte becomes a continuation)
            if (mix >= 82)
            begin
                at = $urandom_range(seq.size() - 1);
                if ($urandom_range(1) == 0)
                    seq[at] = 8'($urandom_range(255));
                else if (seq.size() > 1)
                    void'(seq.pop_back());
                else
                    seq[at] = 8'($urandom_range(s8d_pkg::CONT_LO, s8d_pkg::CONT_HI));
            end
        end
        foreach (seq[i])
        begin
            x.data_byte = seq[i];
            x.is_end    = 1'b0;
            byte_plan.push_back(x);
        end
    endtask

    // Receiver: checks every result taken and pops at random.
    initial
    begin
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (predicted_cps.size() == 0)
                    note_mismatch("unexpected result, code_point",
                                  32'(result.code_point), '0);
                else
                begin
                    if (result.code_point !== predicted_cps[0].code_point)
                        note_mismatch("code_point", 32'(result.code_point),
                                      32'(predicted_cps[0].code_point));
                    if (result.status !== predicted_cps[0].status)
                        note_mismatch("status", 32'(result.status),
                                      32'(predicted_cps[0].status));
                    if (result.seq_offset !== predicted_cps[0].seq_offset)
                        note_mismatch("seq_offset", result.seq_offset,
                                      predicted_cps[0].seq_offset);
                    if (result.last_result !== predicted_cps[0].last_result)
                        note_mismatch("last_result", 32'(result.last_result),
                                      32'(predicted_cps[0].last_result));
                    void'(predicted_cps.pop_front());
                end
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Sender and run control.
    initial
    begin
        int            ph;
        int            goal;
        s8d_pkg::out_t none;
        rst_n      <= 1'b0;
        push       <= 1'b0;
        item       <= '0;
        gap_pct     = 0;
        stall_pct   = 0;
        mismatches  = 0;
        fed_items   = 0;
        held_n      = 0;
        held_bytes  = '0;
        next_off    = '0;
        none        = '0;

        // Directed table. Offsets count from 0 after reset.
        add_row(8'h00, 1'b0, 1'b1, 21'h0, s8d_pkg::ST_OK, 32'd0);            // lowest byte
        add_row(8'h80, 1'b0, 1'b1, s8d_pkg::CP_REPL, s8d_pkg::ST_INVALID,
                32'd1);                                                      // lone continuation
        add_row(8'hFF, 1'b0, 1'b1, s8d_pkg::CP_REPL, s8d_pkg::ST_INVALID,
                32'd2);                                                      // highest byte
        add_row(8'hC1, 1'b0, 1'b1, s8d_pkg::CP_REPL, s8d_pkg::ST_INVALID,
                32'd3);                                                      // overlong 2-byte lead
        add_row(8'hF5, 1'b0, 1'b1, s8d_pkg::CP_REPL, s8d_pkg::ST_INVALID,
                32'd4);                                                      // first lead above range
        add_row(8'hC2, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);                  // U+0080, nothing yet
        add_row(8'h80, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        // E0 9F 80: overlong, held until complete, then three replacements
        add_row(8'hE0, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'h9F, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'h80, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        // ED A0 80: surrogate
        add_row(8'hED, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'hA0, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'h80, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        // F4 90 80 80: above U+10FFFF, four results from one byte
        add_row(8'hF4, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'h90, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'h80, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'h80, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        // F0 9F 98 80: a good 4-byte scalar
        add_row(8'hF0, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'h9F, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'h98, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'h80, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        // E2 82 then flush: incomplete at its lead; the flush byte is ignored
        add_row(8'hE2, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'h82, 1'b0, 1'b0, '0, s8d_pkg::ST_OK, '0);
        add_row(8'hFF, 1'b1, 1'b1, s8d_pkg::CP_REPL, s8d_pkg::ST_INCOMPLETE, 32'd21);
        // second flush right away: clean end at offset 0
        add_row(8'h00, 1'b1, 1'b1, 21'h0, s8d_pkg::ST_CLEAN_END, 32'd0);

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            feed(rows[i].stim, rows[i].typed, rows[i].want);

        // Random part in four idling phases: none, sender sparse,
        // receiver stalling, both a little.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 84;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 84;
                end
                default:
                begin
                    gap_pct   = 25;
                    stall_pct = 25;
                end
            endcase
            goal = fed_items + 84;
            while (fed_items < goal)
            begin
                plan_burst();
                while (byte_plan.size() > 0)
                    feed(byte_plan.pop_front(), 1'b0, none);
            end
        end
        push <= 1'b0;

        // drain, then keep the clock running so that any extra result would show
        while (predicted_cps.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
design/s8d_pkg.sv
design/s8d_fifo.sv
design/s8d_front.sv
design/s8d_back.sv
design/strict_utf8_stream_decoder.sv
bench/tb_strict_utf8_stream_decoder.sv
